// ===== hw/rtl/pcoe_pkg.sv =====
// ----------------------------------------------------------------------------
// pcoe_pkg
// Shared types and constants of the piecewise cubic offset evaluator.
// ----------------------------------------------------------------------------
package pcoe_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int SEG_IDX_W    = 4;
  localparam int CNT_W        = 5;
  localparam int POS_W        = 32;
  localparam int COEF_W       = 48;
  localparam int ACC_W        = 160;
  localparam int LIMB_W       = 32;
  localparam int LIMBS        = ACC_W / LIMB_W;
  localparam int FRAC_SHIFT   = 36;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic        [POS_W-1:0]  start;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } seg_entry_t;

  function automatic logic [ACC_W-1:0] sext_coef(input logic [COEF_W-1:0] x);
    sext_coef = {{(ACC_W-COEF_W){x[COEF_W-1]}}, x};
  endfunction

endpackage

// ===== hw/rtl/pcoe_seg_mem.sv =====
// ----------------------------------------------------------------------------
// pcoe_seg_mem
// Segment table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcoe_seg_mem (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [pcoe_pkg::SEG_IDX_W-1:0] wr_addr,
  input  pcoe_pkg::seg_entry_t           wr_data,
  input  logic                           rd_en,
  input  logic [pcoe_pkg::SEG_IDX_W-1:0] rd_addr,
  output pcoe_pkg::seg_entry_t           rd_data
);
  import pcoe_pkg::*;

  seg_entry_t mem [MAX_SEGMENTS];
  seg_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/pcoe_horner.sv =====
// ----------------------------------------------------------------------------
// pcoe_horner
// Horner evaluation of d,c,b,a at ds on one shared 32x32 multiplier, limb by
// limb over a 160-bit accumulator, then rounding and saturation to Q16.32.
// ----------------------------------------------------------------------------
module pcoe_horner (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [pcoe_pkg::POS_W-1:0]   ds,
  input  pcoe_pkg::seg_entry_t         coef,
  output logic                         done,
  output logic [pcoe_pkg::COEF_W-1:0]  value,
  output logic                         sat
);
  import pcoe_pkg::*;

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_ADD, H_FIN} hstate_t;

  hstate_t             state_r, state_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [LIMB_W-1:0]   carry_r, carry_nxt;
  logic [2:0]          limb_r, limb_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [POS_W-1:0]    ds_r, ds_nxt;
  seg_entry_t          coef_r, coef_nxt;
  logic                done_r, done_nxt;
  logic [COEF_W-1:0]   value_r, value_nxt;
  logic                sat_r, sat_nxt;

  logic [LIMB_W-1:0]   limb_val;
  logic [2*LIMB_W-1:0] prod;
  logic [2*LIMB_W-1:0] prod_sum;
  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    c_ext, b_ext, a_ext;
  logic [ACC_W-1:FRAC_SHIFT+COEF_W-1] hi_bits;
  logic                fits;

  assign limb_val = acc_r[{limb_r, 5'b00000} +: LIMB_W];
  assign prod     = limb_val * ds_r;
  assign prod_sum = prod + {{LIMB_W{1'b0}}, carry_r};

  assign c_ext = sext_coef(coef_r.c);
  assign b_ext = sext_coef(coef_r.b);
  assign a_ext = sext_coef(coef_r.a);

  // last term also carries the half-lsb for round half up
  always_comb begin
    unique case (step_r)
      2'd0:    addend = {c_ext[ACC_W-13:0], 12'b0};
      2'd1:    addend = {b_ext[ACC_W-25:0], 24'b0};
      default: addend = {a_ext[ACC_W-FRAC_SHIFT-1:0], 1'b1, 35'b0};
    endcase
  end

  assign hi_bits = acc_r[ACC_W-1:FRAC_SHIFT+COEF_W-1];
  assign fits    = (&hi_bits) | ~(|hi_bits);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    limb_nxt  = limb_r;
    step_nxt  = step_r;
    ds_nxt    = ds_r;
    coef_nxt  = coef_r;
    done_nxt  = 1'b0;
    value_nxt = value_r;
    sat_nxt   = sat_r;
    unique case (state_r)
      H_IDLE: begin
        if (go) begin
          acc_nxt   = sext_coef(coef.d);
          coef_nxt  = coef;
          ds_nxt    = ds;
          carry_nxt = '0;
          limb_nxt  = '0;
          step_nxt  = '0;
          state_nxt = H_MUL;
        end
      end
      H_MUL: begin
        acc_nxt[{limb_r, 5'b00000} +: LIMB_W] = prod_sum[LIMB_W-1:0];
        carry_nxt = prod_sum[2*LIMB_W-1:LIMB_W];
        if (limb_r == 3'(LIMBS - 1)) begin
          limb_nxt  = '0;
          state_nxt = H_ADD;
        end else begin
          limb_nxt = limb_r + 3'd1;
        end
      end
      H_ADD: begin
        acc_nxt   = acc_r + addend;
        carry_nxt = '0;
        if (step_r == 2'd2) begin
          state_nxt = H_FIN;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = H_MUL;
        end
      end
      default: begin
        done_nxt = 1'b1;
        if (fits) begin
          value_nxt = acc_r[FRAC_SHIFT+COEF_W-1:FRAC_SHIFT];
          sat_nxt   = 1'b0;
        end else begin
          value_nxt = acc_r[ACC_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}};
          sat_nxt   = 1'b1;
        end
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
    limb_r  <= limb_nxt;
    step_r  <= step_nxt;
    ds_r    <= ds_nxt;
    coef_r  <= coef_nxt;
    value_r <= value_nxt;
    sat_r   <= sat_nxt;
  end

  assign done  = done_r;
  assign value = value_r;
  assign sat   = sat_r;

endmodule

// ===== hw/rtl/piecewise_cubic_offset_eval_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_offset_eval_unit
// Segment table plus cubic evaluation of the lateral offset at a query point.
// ----------------------------------------------------------------------------
// load beat: written at the accepting edge, busy stays low, no result.
// query beat: table scan (one memory read per entry, n = num_segments clamped
//   to 16), fetch of the chosen entry, horner on the shared 32x32 multiplier,
//   then the output register; one query at a time, next start taken on out_valid.
// no matching segment: result comes straight after the scan; with n = 0 there is no scan.
// synchronous reset clears control and num_segments; table content undefined.
module piecewise_cubic_offset_eval_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [pcoe_pkg::SEG_IDX_W-1:0]      in_seg_index,
  input  logic [pcoe_pkg::POS_W-1:0]          in_seg_start,
  input  logic signed [pcoe_pkg::COEF_W-1:0]  in_coef_a,
  input  logic signed [pcoe_pkg::COEF_W-1:0]  in_coef_b,
  input  logic signed [pcoe_pkg::COEF_W-1:0]  in_coef_c,
  input  logic signed [pcoe_pkg::COEF_W-1:0]  in_coef_d,
  input  logic [pcoe_pkg::POS_W-1:0]          in_query_pos,
  output logic                                out_valid,
  output logic signed [pcoe_pkg::COEF_W-1:0]  out_offset_value,
  output logic                                out_found,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcoe_pkg::CNT_W-1:0]          cfg_data
);
  import pcoe_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_FETCH, ST_LOAD, ST_EVAL} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     num_r, num_nxt;
  logic [POS_W-1:0]     q_r, q_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic                 pend_r, pend_nxt;
  logic [SEG_IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic                 best_found_r, best_found_nxt;
  logic [SEG_IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [POS_W-1:0]     best_start_r, best_start_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0]    out_value_r, out_value_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic                 accept;
  logic                 mem_wr_en;
  seg_entry_t           mem_wr_data;
  logic                 mem_rd_en;
  logic [SEG_IDX_W-1:0] mem_rd_addr;
  seg_entry_t           mem_rd_data;
  logic                 hit;
  logic                 scan_last;
  logic [CNT_W-1:0]     n_clamped;
  logic                 h_go;
  logic                 h_done;
  logic [COEF_W-1:0]    h_value;
  logic                 h_sat;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = ~busy;

  assign n_clamped = (num_r > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : num_r;

  assign mem_wr_en = accept && (in_cmd == CMD_LOAD) &&
                     ({1'b0, in_seg_index} < CNT_W'(MAX_SEGMENTS));
  assign mem_wr_data.start = in_seg_start;
  assign mem_wr_data.a     = in_coef_a;
  assign mem_wr_data.b     = in_coef_b;
  assign mem_wr_data.c     = in_coef_c;
  assign mem_wr_data.d     = in_coef_d;

  assign mem_rd_en   = ((state_r == ST_SCAN) && (issue_r < n_r)) || (state_r == ST_FETCH);
  assign mem_rd_addr = (state_r == ST_FETCH) ? best_idx_r : issue_r[SEG_IDX_W-1:0];

  // strict greater keeps the lowest index among equal starts
  assign hit = pend_r && (mem_rd_data.start <= q_r) &&
               (!best_found_r || (mem_rd_data.start > best_start_r));
  assign scan_last = pend_r && (issue_r == n_r);

  assign h_go = (state_r == ST_LOAD);

  pcoe_seg_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (in_seg_index),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  pcoe_horner u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (h_go),
    .ds    (q_r - best_start_r),
    .coef  (mem_rd_data),
    .done  (h_done),
    .value (h_value),
    .sat   (h_sat)
  );

  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    q_nxt          = q_r;
    n_nxt          = n_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_found_nxt  = out_found_r;
    out_sat_nxt    = out_sat_r;

    if (cfg_valid && cfg_ready) begin
      num_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_cmd == CMD_QUERY)) begin
          q_nxt          = in_query_pos;
          n_nxt          = n_clamped;
          issue_nxt      = '0;
          best_found_nxt = 1'b0;
          if (n_clamped == '0) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_found_nxt = 1'b0;
            out_sat_nxt   = 1'b0;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue_r < n_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[SEG_IDX_W-1:0];
          issue_nxt    = issue_r + CNT_W'(1);
        end
        if (hit) begin
          best_found_nxt = 1'b1;
          best_idx_nxt   = pend_idx_r;
          best_start_nxt = mem_rd_data.start;
        end
        if (scan_last) begin
          if (hit || best_found_r) begin
            state_nxt = ST_FETCH;
          end else begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_found_nxt = 1'b0;
            out_sat_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_EVAL;
      end
      default: begin
        if (h_done) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = h_value;
          out_found_nxt = 1'b1;
          out_sat_nxt   = h_sat;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_r        <= '0;
      pend_r       <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      num_r        <= num_nxt;
      pend_r       <= pend_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    q_r          <= q_nxt;
    n_r          <= n_nxt;
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
    out_value_r  <= out_value_nxt;
    out_found_r  <= out_found_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_offset_value = out_value_r;
  assign out_found        = out_found_r;
  assign out_saturated    = out_sat_r;

endmodule
